// ----- design/polyline_arc_length_resampler_assert.svh -----
// Assertion macros used by the resampler sequencer (plar_ctrl).
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_ASSERT_SVH

// Plain invariant, checked at every clock edge out of reset.
`define PLAR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PLAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/plar_pkg.sv -----
// Shared types and constants for the polyline arc-length resampler.
package plar_pkg;

    localparam int POINT_LIMIT_DEF = 128;
    localparam logic [7:0] MIN_SPACING = 8'd6;
    localparam logic [4:0] ITER_LAST = 5'd16;   // 17 steps for sqrt and divide

    localparam logic [7:0]  SPACING_RST = 8'd12;
    localparam logic [15:0] SCALE_RST   = 16'd16384;

    typedef enum logic [1:0] {
        CFG_SPACING  = 2'd0,
        CFG_SCALE    = 2'd1,
        CFG_OFFSET_X = 2'd2,
        CFG_OFFSET_Y = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SQRT,
        ST_WALK_INIT,
        ST_WALK,
        ST_DIV,
        ST_INTERP,
        ST_MAP,
        ST_TAIL,
        ST_TAIL_CHK,
        ST_EMIT,
        ST_BARE
    } state_t;

    typedef enum logic [1:0] {
        MODE_HEAD,
        MODE_WALK,
        MODE_TAIL
    } mode_t;

    typedef struct packed {
        logic ld_in;
        logic head;
        logic sqrt_step;
        logic walk_init;
        logic walk_step;
        logic walk_exit;
        logic div_step;
        logic interp;
        logic map;
        logic tail;
        logic emit;
        logic emit_end;
        logic bare;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic room;
        logic room_head;
        logic seg_zero;
        logic walk_ok;
        logic dup;
        logic cnt_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/plar_ctrl.sv -----
// Sequencing state machine of the resampler.
`include "polyline_arc_length_resampler_assert.svh"
module plar_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  plar_pkg::dp_status_t  st,
    output plar_pkg::ctrl_cmd_t   cmd
);

    plar_pkg::state_t state_reg, state_next;
    plar_pkg::mode_t  mode_reg, mode_next;
    logic accept;

    assign in_stall = (state_reg != plar_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plar_pkg::ST_IDLE;
            mode_reg  <= plar_pkg::MODE_HEAD;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            plar_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = plar_pkg::ST_HEAD;
            end
            plar_pkg::ST_HEAD:
            begin
                if (st.first)
                begin
                    mode_next  = plar_pkg::MODE_HEAD;
                    state_next = st.room_head ? plar_pkg::ST_MAP : plar_pkg::ST_TAIL;
                end
                else
                    state_next = st.room_head ? plar_pkg::ST_SQRT : plar_pkg::ST_TAIL;
            end
            plar_pkg::ST_SQRT:
            begin
                if (st.cnt_done)
                    state_next = plar_pkg::ST_WALK_INIT;
            end
            plar_pkg::ST_WALK_INIT:
                state_next = st.seg_zero ? plar_pkg::ST_TAIL : plar_pkg::ST_WALK;
            plar_pkg::ST_WALK:
            begin
                if (st.walk_ok)
                begin
                    mode_next  = plar_pkg::MODE_WALK;
                    state_next = plar_pkg::ST_DIV;
                end
                else
                    state_next = plar_pkg::ST_TAIL;
            end
            plar_pkg::ST_DIV:
            begin
                if (st.cnt_done)
                    state_next = plar_pkg::ST_INTERP;
            end
            plar_pkg::ST_INTERP:
                state_next = plar_pkg::ST_MAP;
            plar_pkg::ST_MAP:
                state_next = (mode_reg == plar_pkg::MODE_TAIL) ? plar_pkg::ST_TAIL_CHK
                                                               : plar_pkg::ST_EMIT;
            plar_pkg::ST_TAIL:
            begin
                if (st.last)
                begin
                    mode_next  = plar_pkg::MODE_TAIL;
                    state_next = plar_pkg::ST_MAP;
                end
                else
                    state_next = plar_pkg::ST_IDLE;
            end
            plar_pkg::ST_TAIL_CHK:
                state_next = (st.room && !st.dup) ? plar_pkg::ST_EMIT : plar_pkg::ST_BARE;
            plar_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    case (mode_reg)
                        plar_pkg::MODE_HEAD: state_next = plar_pkg::ST_TAIL;
                        plar_pkg::MODE_WALK: state_next = plar_pkg::ST_WALK;
                        default:             state_next = plar_pkg::ST_IDLE;
                    endcase
                end
            end
            plar_pkg::ST_BARE:
            begin
                if (st.out_free)
                    state_next = plar_pkg::ST_IDLE;
            end
            default:
                state_next = plar_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            plar_pkg::ST_IDLE:      cmd.ld_in     = accept;
            plar_pkg::ST_HEAD:      cmd.head      = 1'b1;
            plar_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
            plar_pkg::ST_WALK_INIT: cmd.walk_init = 1'b1;
            plar_pkg::ST_WALK:
            begin
                cmd.walk_step = st.walk_ok;
                cmd.walk_exit = !st.walk_ok;
            end
            plar_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            plar_pkg::ST_INTERP:    cmd.interp    = 1'b1;
            plar_pkg::ST_MAP:       cmd.map       = 1'b1;
            plar_pkg::ST_TAIL:      cmd.tail      = 1'b1;
            plar_pkg::ST_EMIT:
            begin
                cmd.emit     = st.out_free;
                cmd.emit_end = (mode_reg == plar_pkg::MODE_TAIL);
            end
            plar_pkg::ST_BARE:      cmd.bare      = st.out_free;
            default:                cmd           = '0;
        endcase
    end

    `PLAR_ASSERT_NEXT(a_accept_head, accept, state_reg == plar_pkg::ST_HEAD, "accept did not start HEAD")
    `PLAR_ASSERT(a_emit_free, !(cmd.emit || cmd.bare) || st.out_free, "word loaded into busy output")
    `PLAR_ASSERT_NEXT(a_sqrt_done, (state_reg == plar_pkg::ST_SQRT) && st.cnt_done, state_reg == plar_pkg::ST_WALK_INIT, "sqrt did not finish into walk")

endmodule

// ----- design/plar_dp.sv -----
// Datapath of the resampler: registers, sqrt, divider, interpolation, output word.
module plar_dp #(
    parameter int POINT_LIMIT = plar_pkg::POINT_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [7:0]            vertex_x,
    input  logic [7:0]            vertex_y,
    input  logic                  stroke_first,
    input  logic                  stroke_last,
    input  logic                  drawing_first,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [10:0]           point_x,
    output logic [10:0]           point_y,
    output logic                  point_valid,
    output logic                  stroke_end,
    output logic [7:0]            stroke_points,
    input  plar_pkg::ctrl_cmd_t   cmd,
    output plar_pkg::dp_status_t  st
);

    localparam logic [7:0] LIMIT = 8'(POINT_LIMIT);

    logic [7:0]  spacing_reg;
    logic [15:0] scale_reg;
    logic [9:0]  offx_reg, offy_reg;
    logic [7:0]  vx_reg, vy_reg;
    logic        first_reg, last_reg, draw_reg;
    logic [7:0]  prev_x_reg, prev_y_reg;
    logic [16:0] carry_reg;
    logic [10:0] last_x_reg, last_y_reg;
    logic [7:0]  stroke_reg, total_reg;
    logic signed [8:0] dx_reg, dy_reg;
    logic [33:0] rad_reg;
    logic [19:0] srem_reg;
    logic [16:0] root_reg;
    logic [16:0] walked_reg, d_reg;
    logic [17:0] drem_reg;
    logic [16:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [7:0]  src_x_reg, src_y_reg;
    logic [10:0] map_x_reg, map_y_reg;
    logic        out_valid_reg;
    logic [10:0] px_reg, py_reg;
    logic        pv_reg, pe_reg;
    logic [7:0]  sp_reg;

    logic [7:0]  sp_eff;
    logic [15:0] full;
    logic signed [8:0] dx, dy;
    logic [17:0] sq;
    logic [20:0] rem_sh, trial, rem_sub;
    logic        sq_ge;
    logic [17:0] sum;
    logic        dv_ge;
    logic [17:0] dv_r;
    logic signed [18:0] left;
    logic signed [26:0] ip_x, ip_y;
    logic [23:0] prod_x, prod_y;
    logic [10:0] mx, my;
    logic        out_free;

    assign sp_eff = (spacing_reg < plar_pkg::MIN_SPACING) ? plar_pkg::MIN_SPACING : spacing_reg;
    assign full   = {sp_eff, 8'd0};

    assign dx = $signed({1'b0, vx_reg}) - $signed({1'b0, prev_x_reg});
    assign dy = $signed({1'b0, vy_reg}) - $signed({1'b0, prev_y_reg});
    // widen before squaring so a full-range difference keeps every bit
    assign sq = unsigned'(18'(dx) * 18'(dx)) + unsigned'(18'(dy) * 18'(dy));

    // one root bit per step
    assign rem_sh  = {srem_reg[18:0], rad_reg[33:32]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sq_ge   = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    assign sum   = {1'b0, walked_reg} + {1'b0, d_reg};
    assign dv_ge = (drem_reg >= {1'b0, root_reg});
    assign dv_r  = dv_ge ? (drem_reg - {1'b0, root_reg}) : drem_reg;
    assign left  = $signed({2'b00, d_reg}) -
                   ($signed({2'b00, root_reg}) - $signed({2'b00, walked_reg}));

    assign ip_x = $signed({3'b000, prev_x_reg, 16'd0}) + dx_reg * $signed({1'b0, quo_reg});
    assign ip_y = $signed({3'b000, prev_y_reg, 16'd0}) + dy_reg * $signed({1'b0, quo_reg});

    assign prod_x = src_x_reg * scale_reg;
    assign prod_y = src_y_reg * scale_reg;
    assign mx = {1'b0, offx_reg} + {1'b0, prod_x[23:14]};
    assign my = {1'b0, offy_reg} + {1'b0, prod_y[23:14]};

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st.first     = first_reg;
        st.last      = last_reg;
        st.room      = (total_reg < LIMIT);
        st.room_head = draw_reg || (total_reg < LIMIT);
        st.seg_zero  = (root_reg == '0);
        st.walk_ok   = (sum <= {1'b0, root_reg}) && (total_reg < LIMIT);
        st.dup       = (stroke_reg != '0) && (last_x_reg == map_x_reg) &&
                       (last_y_reg == map_y_reg);
        st.cnt_done  = (cnt_reg == plar_pkg::ITER_LAST);
        st.out_free  = out_free;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= plar_pkg::SPACING_RST;
            scale_reg     <= plar_pkg::SCALE_RST;
            offx_reg      <= '0;
            offy_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            carry_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            stroke_reg    <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (plar_pkg::cfg_index_t'(cfg_index))
                    plar_pkg::CFG_SPACING:  spacing_reg <= cfg_data[7:0];
                    plar_pkg::CFG_SCALE:    scale_reg   <= cfg_data;
                    plar_pkg::CFG_OFFSET_X: offx_reg    <= cfg_data[9:0];
                    plar_pkg::CFG_OFFSET_Y: offy_reg    <= cfg_data[9:0];
                    default:                spacing_reg <= spacing_reg;
                endcase
            end
            if (cmd.head)
            begin
                if (draw_reg)
                    total_reg <= '0;
                if (first_reg)
                begin
                    stroke_reg <= '0;
                    carry_reg  <= {1'b0, full};
                end
                cnt_reg <= '0;
            end
            if (cmd.sqrt_step || cmd.div_step)
                cnt_reg <= cnt_reg + 5'd1;
            if (cmd.walk_step)
                cnt_reg <= '0;
            if (cmd.walk_exit)
                carry_reg <= (!left[18] && (left != '0)) ? left[16:0] : '0;
            if (cmd.tail)
            begin
                prev_x_reg <= vx_reg;
                prev_y_reg <= vy_reg;
            end
            if (cmd.emit)
            begin
                last_x_reg <= map_x_reg;
                last_y_reg <= map_y_reg;
                stroke_reg <= stroke_reg + 8'd1;
                total_reg  <= total_reg + 8'd1;
            end
            if (cmd.emit || cmd.bare)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            vx_reg    <= vertex_x;
            vy_reg    <= vertex_y;
            first_reg <= stroke_first;
            last_reg  <= stroke_last;
            draw_reg  <= drawing_first;
        end
        if (cmd.head)
        begin
            src_x_reg <= vx_reg;
            src_y_reg <= vy_reg;
            dx_reg    <= dx;
            dy_reg    <= dy;
            rad_reg   <= {sq, 16'd0};
            srem_reg  <= '0;
            root_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            srem_reg <= sq_ge ? rem_sub[19:0] : rem_sh[19:0];
            root_reg <= {root_reg[15:0], sq_ge};
            rad_reg  <= {rad_reg[31:0], 2'b00};
        end
        if (cmd.walk_init)
        begin
            walked_reg <= '0;
            d_reg      <= (carry_reg != '0) ? carry_reg : {1'b0, full};
        end
        if (cmd.walk_step)
        begin
            walked_reg <= sum[16:0];
            d_reg      <= {1'b0, full};
            drem_reg   <= {1'b0, sum[16:0]};
            quo_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[15:0], dv_ge};
            drem_reg <= {dv_r[16:0], 1'b0};
        end
        if (cmd.interp)
        begin
            src_x_reg <= ip_x[23:16];
            src_y_reg <= ip_y[23:16];
        end
        if (cmd.tail)
        begin
            src_x_reg <= vx_reg;
            src_y_reg <= vy_reg;
        end
        if (cmd.map)
        begin
            map_x_reg <= mx;
            map_y_reg <= my;
        end
        if (cmd.emit)
        begin
            px_reg <= map_x_reg;
            py_reg <= map_y_reg;
            pv_reg <= 1'b1;
            pe_reg <= cmd.emit_end;
            sp_reg <= stroke_reg + 8'd1;
        end
        if (cmd.bare)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pv_reg <= 1'b0;
            pe_reg <= 1'b1;
            sp_reg <= stroke_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;
    assign point_valid   = pv_reg;
    assign stroke_end    = pe_reg;
    assign stroke_points = sp_reg;

endmodule

// ----- design/polyline_arc_length_resampler.sv -----
// Top level of the polyline arc-length resampler.
//
// Input channel: one vertex word per handshake (vertex_x, vertex_y and the
// stroke_first / stroke_last / drawing_first marks), taken when in_valid is
// high and in_stall is low. in_stall is high whenever a vertex is in work.
// Output channel: waypoint words on out_valid / out_stall; a finished word
// sits in the output register while the block goes on with the next point.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 spacing,
// 1 scale, 2 offset x, 3 offset y); write only while the block is idle.
// Steps: a stroke-opening vertex is scaled and loaded with no length step; a
// continuation vertex first gets its segment length (17-step bit-serial
// square root), then for each emitted point runs a 17-step restoring
// divider, interpolate, scale and load. The shared iteration counter and
// the divider set the rate; one vertex is worked on at a time.
// Reset (rst_n low, asynchronous) returns spacing 12, scale 1.0, zero
// offsets and zero tracking state. A stalled receiver holds the output
// word; the sequencer waits at its next emit until the word is taken.
module polyline_arc_length_resampler #(
    parameter int POINT_LIMIT = plar_pkg::POINT_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  vertex_x,
    input  logic [7:0]  vertex_y,
    input  logic        stroke_first,
    input  logic        stroke_last,
    input  logic        drawing_first,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] point_x,
    output logic [10:0] point_y,
    output logic        point_valid,
    output logic        stroke_end,
    output logic [7:0]  stroke_points
);

    plar_pkg::ctrl_cmd_t  cmd;
    plar_pkg::dp_status_t st;

    // sequencer: walks each vertex through length, steps and end handling
    plar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: holds state, computes length, ratio and mapped points
    plar_dp #(
        .POINT_LIMIT (POINT_LIMIT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .stroke_first  (stroke_first),
        .stroke_last   (stroke_last),
        .drawing_first (drawing_first),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_valid   (point_valid),
        .stroke_end    (stroke_end),
        .stroke_points (stroke_points),
        .cmd           (cmd),
        .st            (st)
    );

endmodule
